// ===== rtl/core/mialu_pkg.sv =====
// ----------------------------------------------------------------------------
// mialu_pkg
// Shared types and constants for the integer ALU with its register file.
// ----------------------------------------------------------------------------
`default_nettype none

package mialu_pkg;

  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned OpW      = 4;
  localparam int unsigned ShamtW   = 5;
  localparam int unsigned ImmW     = 16;

  typedef enum logic [OpW-1:0] {
    OP_SLL   = 4'd0,
    OP_SRL   = 4'd1,
    OP_SRA   = 4'd2,
    OP_SLT   = 4'd3,
    OP_SLTU  = 4'd4,
    OP_SLTI  = 4'd5,
    OP_SLTIU = 4'd6,
    OP_AND   = 4'd7,
    OP_ANDI  = 4'd8,
    OP_ORI   = 4'd9,
    OP_OR    = 4'd10,
    OP_ADDI  = 4'd11,
    OP_ADDU  = 4'd12,
    OP_ADDIU = 4'd13,
    OP_SYNC  = 4'd14
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [RegIdxW-1:0]  rs_idx;
    logic [RegIdxW-1:0]  rt_idx;
    logic [RegIdxW-1:0]  rd_idx;
    logic [ShamtW-1:0]   shamt;
    logic [ImmW-1:0]     imm;
  } item_t;

  typedef struct packed {
    logic                en;
    logic [RegIdxW-1:0]  idx;
    logic [DataW-1:0]    data;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/mialu_ram.sv =====
// ----------------------------------------------------------------------------
// mialu_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mialu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mialu_regfile.sv =====
// ----------------------------------------------------------------------------
// mialu_regfile
// General register file: two RAM copies give two read ports, per-entry valid
// bits give the all-zero reset, and the last write is forwarded to reads that
// were issued in the same cycle as that write.
// ----------------------------------------------------------------------------
`default_nettype none

module mialu_regfile (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            re_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]   raddr_a_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]   raddr_b_i,
  input  wire mialu_pkg::wr_t                  wr_i,
  output logic      [mialu_pkg::DataW-1:0]     rdata_a_o,
  output logic      [mialu_pkg::DataW-1:0]     rdata_b_o
);
  import mialu_pkg::*;

  logic [NumRegs-1:0] valid_q;
  logic               vld_a_q, vld_b_q;
  logic [RegIdxW-1:0] raddr_a_q, raddr_b_q;
  wr_t                last_wr_q;
  logic [DataW-1:0]   ram_a, ram_b;

  mialu_ram #(.Width(DataW), .Depth(NumRegs)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (raddr_a_i),
    .rdata_o (ram_a)
  );

  mialu_ram #(.Width(DataW), .Depth(NumRegs)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (raddr_b_i),
    .rdata_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      raddr_a_q <= '0;
      raddr_b_q <= '0;
      last_wr_q <= '0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
        last_wr_q         <= wr_i;
      end
      if (re_i) begin
        vld_a_q   <= valid_q[raddr_a_i];
        vld_b_q   <= valid_q[raddr_b_i];
        raddr_a_q <= raddr_a_i;
        raddr_b_q <= raddr_b_i;
      end
    end
  end

  // The most recent write is either newer than the RAM data or equal to it.
  always_comb begin
    if (last_wr_q.en && (last_wr_q.idx == raddr_a_q)) begin
      rdata_a_o = last_wr_q.data;
    end else begin
      rdata_a_o = vld_a_q ? ram_a : '0;
    end
    if (last_wr_q.en && (last_wr_q.idx == raddr_b_q)) begin
      rdata_b_o = last_wr_q.data;
    end else begin
      rdata_b_o = vld_b_q ? ram_b : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mialu_alu.sv =====
// ----------------------------------------------------------------------------
// mialu_alu
// Operand selection, the integer operations and destination selection.
// ----------------------------------------------------------------------------
`default_nettype none

module mialu_alu (
  input  wire mialu_pkg::item_t             item_i,
  input  wire logic [mialu_pkg::DataW-1:0]  rs_i,
  input  wire logic [mialu_pkg::DataW-1:0]  rt_i,
  output mialu_pkg::wr_t                    res_o
);
  import mialu_pkg::*;

  logic [DataW-1:0]   simm;
  logic [DataW-1:0]   uimm;
  logic [DataW-1:0]   value;
  logic [RegIdxW-1:0] dest;
  logic               writes;

  assign simm = {{(DataW-ImmW){item_i.imm[ImmW-1]}}, item_i.imm};
  assign uimm = {{(DataW-ImmW){1'b0}}, item_i.imm};

  always_comb begin
    value  = '0;
    dest   = item_i.rd_idx;
    writes = 1'b1;
    case (item_i.op)
      OP_SLL:   value = rt_i << item_i.shamt;
      OP_SRL:   value = rt_i >> item_i.shamt;
      OP_SRA:   value = DataW'($signed(rt_i) >>> item_i.shamt);
      OP_SLT:   value = {{(DataW-1){1'b0}}, ($signed(rs_i) < $signed(rt_i))};
      OP_SLTU:  value = {{(DataW-1){1'b0}}, (rs_i < rt_i)};
      OP_SLTI: begin
        dest  = item_i.rt_idx;
        value = {{(DataW-1){1'b0}}, ($signed(rs_i) < $signed(simm))};
      end
      OP_SLTIU: begin
        dest  = item_i.rt_idx;
        value = {{(DataW-1){1'b0}}, (rs_i < simm)};
      end
      OP_AND:   value = rs_i & rt_i;
      OP_ANDI: begin
        dest  = item_i.rt_idx;
        value = rs_i & uimm;
      end
      OP_ORI: begin
        dest  = item_i.rt_idx;
        value = rs_i | uimm;
      end
      OP_OR:    value = rs_i | rt_i;
      OP_ADDI, OP_ADDIU: begin
        dest  = item_i.rt_idx;
        value = rs_i + simm;
      end
      OP_ADDU:  value = rs_i + rt_i;
      default:  writes = 1'b0;
    endcase

    if (writes && (dest != '0)) begin
      res_o.en   = 1'b1;
      res_o.idx  = dest;
      res_o.data = value;
    end else begin
      res_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mips_integer_alu_regfile.sv =====
// ----------------------------------------------------------------------------
// mips_integer_alu_regfile
// MIPS-I integer ALU with a 32 x 32-bit general register file.
// ----------------------------------------------------------------------------
// The block takes one decoded instruction per cycle while the input is not
// stalled and returns one result beat per instruction. The register file RAMs capture
// both source registers at the accepting edge. The result is then computed
// from the registered instruction, and when that instruction advances, the
// block writes the register file and loads the output register. The input
// stalls only while an instruction waits behind a full output register whose
// beat is stalled. A result from the previous instruction is forwarded, so
// dependent instructions run back to back. The register file reads as zero
// after reset through per-register valid bits, so no clearing pass is needed
// and the block accepts beats right after reset. Register zero is never
// written and always reads as zero.
`default_nettype none

module mips_integer_alu_regfile (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                stall_o,
  input  wire logic [mialu_pkg::OpW-1:0]      operation_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  src_a_index_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  src_b_index_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  dest_index_i,
  input  wire logic [mialu_pkg::ShamtW-1:0]   shift_amount_i,
  input  wire logic [mialu_pkg::ImmW-1:0]     immediate_i,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic                                write_enable_o,
  output logic      [mialu_pkg::RegIdxW-1:0]  written_index_o,
  output logic      [mialu_pkg::DataW-1:0]    written_value_o
);
  import mialu_pkg::*;

  logic             accept;
  logic             advance;
  logic             s1_valid_q, s1_valid_d;
  item_t            s1_item_q;
  logic             out_valid_q, out_valid_d;
  wr_t              out_q;
  logic [DataW-1:0] rs_data, rt_data;
  wr_t              res;
  wr_t              rf_wr;

  assign advance = s1_valid_q && (!out_valid_q || !stall_i);
  assign stall_o = s1_valid_q && out_valid_q && stall_i;
  assign accept  = valid_i && !stall_o;

  assign rf_wr.en   = advance && res.en;
  assign rf_wr.idx  = res.idx;
  assign rf_wr.data = res.data;

  mialu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (accept),
    .raddr_a_i (src_a_index_i),
    .raddr_b_i (src_b_index_i),
    .wr_i      (rf_wr),
    .rdata_a_o (rs_data),
    .rdata_b_o (rt_data)
  );

  mialu_alu u_alu (
    .item_i (s1_item_q),
    .rs_i   (rs_data),
    .rt_i   (rt_data),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (!out_valid_q || !stall_i) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.op     <= op_e'(operation_i);
      s1_item_q.rs_idx <= src_a_index_i;
      s1_item_q.rt_idx <= src_b_index_i;
      s1_item_q.rd_idx <= dest_index_i;
      s1_item_q.shamt  <= shift_amount_i;
      s1_item_q.imm    <= immediate_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign valid_o         = out_valid_q;
  assign write_enable_o  = out_q.en;
  assign written_index_o = out_q.idx;
  assign written_value_o = out_q.data;

endmodule

`default_nettype wire

// ===== tb/mips_integer_alu_regfile_checker.sv =====
// ----------------------------------------------------------------------------
// mips_integer_alu_regfile_checker
// Watches both channels of the integer ALU, keeps its own copy of the
// register file, predicts the write-back beat of every accepted instruction
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_integer_alu_regfile_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_i,
  input  wire logic [mialu_pkg::OpW-1:0]      operation_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  src_a_index_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  src_b_index_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  dest_index_i,
  input  wire logic [mialu_pkg::ShamtW-1:0]   shift_amount_i,
  input  wire logic [mialu_pkg::ImmW-1:0]     immediate_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_stall_i,
  input  wire logic                           write_enable_i,
  input  wire logic [mialu_pkg::RegIdxW-1:0]  written_index_i,
  input  wire logic [mialu_pkg::DataW-1:0]    written_value_i,
  output int unsigned                         error_count_o,
  output int unsigned                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mialu_pkg::*;

  logic [DataW-1:0] shadow_regs [NumRegs];
  wr_t              writeback_q [$];
  int unsigned      mismatches;

  assign error_count_o = mismatches;

  function automatic logic [DataW-1:0] read_shadow(input logic [RegIdxW-1:0] idx);
    return (idx == '0) ? '0 : shadow_regs[idx];
  endfunction

  function automatic wr_t execute_instr(input logic [OpW-1:0] op,
                                        input logic [RegIdxW-1:0] rs,
                                        input logic [RegIdxW-1:0] rt,
                                        input logic [RegIdxW-1:0] rd,
                                        input logic [ShamtW-1:0] sa,
                                        input logic [ImmW-1:0] imm);
    logic [DataW-1:0]   a;
    logic [DataW-1:0]   b;
    logic [DataW-1:0]   simm;
    logic [DataW-1:0]   uimm;
    logic [DataW-1:0]   val;
    logic [RegIdxW-1:0] dst;
    logic               writes;
    wr_t                res;
    a      = read_shadow(rs);
    b      = read_shadow(rt);
    simm   = {{(DataW-ImmW){imm[ImmW-1]}}, imm};
    uimm   = {{(DataW-ImmW){1'b0}}, imm};
    val    = '0;
    dst    = rd;
    writes = 1'b1;
    case (op)
      OP_SLL:   val = b << sa;
      OP_SRL:   val = b >> sa;
      OP_SRA:   val = $signed(b) >>> sa;
      OP_SLT:   val = {{(DataW-1){1'b0}}, $signed(a) < $signed(b)};
      OP_SLTU:  val = {{(DataW-1){1'b0}}, a < b};
      OP_SLTI: begin
        dst = rt;
        val = {{(DataW-1){1'b0}}, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin
        dst = rt;
        val = {{(DataW-1){1'b0}}, a < simm};
      end
      OP_AND:   val = a & b;
      OP_ANDI: begin
        dst = rt;
        val = a & uimm;
      end
      OP_ORI: begin
        dst = rt;
        val = a | uimm;
      end
      OP_OR:    val = a | b;
      OP_ADDI, OP_ADDIU: begin
        dst = rt;
        val = a + simm;
      end
      OP_ADDU:  val = a + b;
      default:  writes = 1'b0;
    endcase
    if (!writes || dst == '0) begin
      res = '0;
    end else begin
      res.en   = 1'b1;
      res.idx  = dst;
      res.data = val;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t ns: write-back %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wr_t want;
    wr_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) shadow_regs[i] = '0;
      writeback_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (writeback_q.size() == 0) begin
          report_mismatch("beat count", DataW'(1), DataW'(0));
        end else begin
          want = writeback_q.pop_front();
          if (write_enable_i !== want.en)
            report_mismatch("enable", DataW'(write_enable_i), DataW'(want.en));
          if (written_index_i !== want.idx)
            report_mismatch("index", DataW'(written_index_i), DataW'(want.idx));
          if (written_value_i !== want.data)
            report_mismatch("value", written_value_i, want.data);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred = execute_instr(operation_i, src_a_index_i, src_b_index_i, dest_index_i,
                             shift_amount_i, immediate_i);
        if (pred.en) shadow_regs[pred.idx] = pred.data;
        writeback_q.push_back(pred);
      end
      pending_o <= writeback_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/mips_integer_alu_regfile_tb.sv =====
// ----------------------------------------------------------------------------
// mips_integer_alu_regfile_tb
// Drives directed and random MIPS-I integer instructions into the ALU with
// random idle cycles on the input and random stalls on the output, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_integer_alu_regfile_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mialu_pkg::*;

  localparam logic [OpW-1:0] OpUndefined = 4'd15;
  localparam int unsigned    RandomItems = 550;
  localparam int unsigned    CycleLimit  = 100000;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                valid_i        = 1'b0;
  logic [OpW-1:0]      operation_i    = '0;
  logic [RegIdxW-1:0]  src_a_index_i  = '0;
  logic [RegIdxW-1:0]  src_b_index_i  = '0;
  logic [RegIdxW-1:0]  dest_index_i   = '0;
  logic [ShamtW-1:0]   shift_amount_i = '0;
  logic [ImmW-1:0]     immediate_i    = '0;
  logic                stall_i        = 1'b0;
  logic                stall_o;
  logic                valid_o;
  logic                write_enable_o;
  logic [RegIdxW-1:0]  written_index_o;
  logic [DataW-1:0]    written_value_o;

  logic                steady = 1'b0;
  int unsigned         cycles = 0;
  int unsigned         error_count;
  int unsigned         pending;

  always #6 clk_i = ~clk_i;

  mips_integer_alu_regfile dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .operation_i     (operation_i),
    .src_a_index_i   (src_a_index_i),
    .src_b_index_i   (src_b_index_i),
    .dest_index_i    (dest_index_i),
    .shift_amount_i  (shift_amount_i),
    .immediate_i     (immediate_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .write_enable_o  (write_enable_o),
    .written_index_o (written_index_o),
    .written_value_o (written_value_o)
  );

  mips_integer_alu_regfile_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (valid_i),
    .in_stall_i      (stall_o),
    .operation_i     (operation_i),
    .src_a_index_i   (src_a_index_i),
    .src_b_index_i   (src_b_index_i),
    .dest_index_i    (dest_index_i),
    .shift_amount_i  (shift_amount_i),
    .immediate_i     (immediate_i),
    .out_valid_i     (valid_o),
    .out_stall_i     (stall_i),
    .write_enable_i  (write_enable_o),
    .written_index_i (written_index_o),
    .written_value_i (written_value_o),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || steady) begin
      stall_i <= 1'b0;
    end else begin
      stall_i <= ($urandom_range(0, 99) < 28);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("mips_integer_alu_regfile_tb: errors");
      $finish;
    end
  end

  task automatic issue(input logic [OpW-1:0] op, input logic [RegIdxW-1:0] rs,
                       input logic [RegIdxW-1:0] rt, input logic [RegIdxW-1:0] rd,
                       input logic [ShamtW-1:0] sa, input logic [ImmW-1:0] imm);
    int unsigned gap;
    logic        stalled;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 28) gap++;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i        <= 1'b1;
    operation_i    <= op;
    src_a_index_i  <= rs;
    src_b_index_i  <= rt;
    dest_index_i   <= rd;
    shift_amount_i <= sa;
    immediate_i    <= imm;
    do begin
      @(negedge clk_i);
      stalled = stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic wait_drain();
    valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [OpW-1:0]     op;
    logic [RegIdxW-1:0] rs;
    logic [RegIdxW-1:0] rt;
    logic [RegIdxW-1:0] rd;
    logic [ImmW-1:0]    imm;
    logic [RegIdxW-1:0] recent;
    recent = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Build all-ones, low-half, sign-bit-only and max-positive values first.
    issue(OP_ADDIU, 5'd0,  5'd1,  5'd0,  5'd0,  16'hFFFF);
    issue(OP_ORI,   5'd0,  5'd2,  5'd0,  5'd0,  16'hFFFF);
    issue(OP_SLL,   5'd0,  5'd1,  5'd3,  5'd31, 16'h0000);
    issue(OP_SRL,   5'd0,  5'd1,  5'd4,  5'd1,  16'h0000);
    issue(OP_ADDI,  5'd4,  5'd5,  5'd0,  5'd0,  16'h0001);
    issue(OP_SRA,   5'd0,  5'd3,  5'd6,  5'd31, 16'h0000);
    issue(OP_SRA,   5'd0,  5'd4,  5'd7,  5'd0,  16'h0000);
    issue(OP_SLL,   5'd0,  5'd2,  5'd8,  5'd0,  16'h0000);
    issue(OP_SLT,   5'd3,  5'd4,  5'd9,  5'd0,  16'h0000);
    issue(OP_SLTU,  5'd3,  5'd4,  5'd10, 5'd0,  16'h0000);
    issue(OP_SLTI,  5'd3,  5'd11, 5'd0,  5'd0,  16'h8000);
    issue(OP_SLTI,  5'd4,  5'd12, 5'd0,  5'd0,  16'h7FFF);
    issue(OP_SLTIU, 5'd4,  5'd13, 5'd0,  5'd0,  16'hFFFF);
    issue(OP_SLTIU, 5'd1,  5'd14, 5'd0,  5'd0,  16'h0000);
    issue(OP_AND,   5'd1,  5'd2,  5'd15, 5'd0,  16'h0000);
    issue(OP_ANDI,  5'd1,  5'd16, 5'd0,  5'd0,  16'hFFFF);
    issue(OP_OR,    5'd3,  5'd2,  5'd17, 5'd0,  16'h0000);
    issue(OP_ADDU,  5'd1,  5'd1,  5'd18, 5'd0,  16'h0000);
    issue(OP_ADDIU, 5'd3,  5'd19, 5'd0,  5'd0,  16'h8000);
    issue(OP_ADDI,  5'd1,  5'd0,  5'd0,  5'd0,  16'h1234);
    issue(OP_ADDU,  5'd1,  5'd1,  5'd0,  5'd0,  16'h0000);
    issue(OP_SYNC,  5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF);
    issue(OpUndefined, 5'd1, 5'd2, 5'd31, 5'd17, 16'hA5A5);
    issue(OP_OR,    5'd0,  5'd0,  5'd31, 5'd0,  16'h0000);
    issue(OP_SRL,   5'd0,  5'd3,  5'd31, 5'd31, 16'h0000);

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 150) steady <= 1'b1;
      if (n == 300) steady <= 1'b0;
      if (n == 420) wait_drain();
      op = OpW'($urandom_range(0, 15));
      rs = ($urandom_range(0, 99) < 40) ? recent : RegIdxW'($urandom_range(0, 31));
      rt = ($urandom_range(0, 99) < 40) ? recent : RegIdxW'($urandom_range(0, 31));
      rd = RegIdxW'($urandom_range(0, 31));
      case ($urandom_range(0, 7))
        0:       imm = 16'h0000;
        1:       imm = 16'hFFFF;
        2:       imm = 16'h8000;
        3:       imm = 16'h7FFF;
        default: imm = ImmW'($urandom);
      endcase
      if (op inside {OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_ADDI, OP_ADDIU}) begin
        recent = rt;
      end else if (op != OP_SYNC && op != OpUndefined) begin
        recent = rd;
      end
      issue(op, rs, rt, rd, ShamtW'($urandom_range(0, 31)), imm);
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("mips_integer_alu_regfile_tb: clean");
    end else begin
      $display("mips_integer_alu_regfile_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
